/* rtl/opb_pkg.sv */
package opb_pkg;

  localparam int PRICE_W        = 63;
  localparam int VOL_W          = 64;
  localparam int UID_W          = 64;
  localparam int RANK_W         = 6;
  localparam int MODE_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int LCNT_W         = 7;
  localparam int LEVELS_DEFAULT = 64;

  localparam logic [MODE_W-1:0] M_APPLY  = 2'd0;
  localparam logic [MODE_W-1:0] M_SET_ID = 2'd1;
  localparam logic [MODE_W-1:0] M_CLEAR  = 2'd2;
  localparam logic [MODE_W-1:0] M_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANK = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic               side;
    logic [PRICE_W-1:0] price;
    logic [VOL_W-1:0]   volume;
    logic [UID_W-1:0]   update_id;
    logic [RANK_W-1:0]  rank;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRICE_W-1:0]  level_price;
    logic [PRICE_W-1:0]  level_volume;
    logic [LCNT_W-1:0]   level_count;
    logic [UID_W-1:0]    last_update_id;
  } result_t;

  typedef struct packed {
    logic go;
    logic ins;
    logic del;
    logic ow;
  } ctrl_t;

endpackage

/* rtl/order_book_price_level_table_top.sv */
// Price level table for one order book: an ask side ranked lowest price
// first and a bid side ranked highest price first, each a row of cells.
// Requests come in on req/req_valid/req_stall, results leave on
// res/res_valid/res_stall; every request gives exactly one result.
// A request is taken only while no other one is in work. At the edge that
// takes it, every cell compares its price with the request's price; at the
// commit that follows, once the output register is free, the cells shift,
// insert or overwrite, the counts move and the result is written to the
// output register. An item thus passes the compare stage and then the
// shift stage of the cell row before its result shows.
// While a result waits under res_stall, a new request is still taken, but
// its result is held back and no further request is taken until the
// output register is free again.
// Reset clears both level counts and sets the stored update id to minus
// one; cell contents are not cleared and need no clearing pass.
module order_book_price_level_table_top import opb_pkg::*; #(
  parameter int LEVELS_PER_SIDE = LEVELS_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    req_valid,
  output logic    req_stall,
  input  req_t    req,
  output logic    res_valid,
  input  logic    res_stall,
  output result_t res
);

  localparam int CW = $clog2(LEVELS_PER_SIDE + 1);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_COMMIT = 1'b1;

  logic                state;
  logic                state_next;
  logic                take;
  logic                commit_go;

  logic [MODE_W-1:0]   mode_q;
  logic                side_q;
  logic [PRICE_W-1:0]  price_q;
  logic [VOL_W-1:0]    vol_q;
  logic [UID_W-1:0]    upd_q;
  logic [RANK_W-1:0]   rank_q;

  logic [CW-1:0]       ask_cnt;
  logic [CW-1:0]       bid_cnt;
  logic [CW-1:0]       ask_cnt_next;
  logic [CW-1:0]       bid_cnt_next;
  logic [UID_W-1:0]    uid;
  logic [UID_W-1:0]    uid_next;

  logic                ask_found;
  logic                bid_found;
  logic [PRICE_W-1:0]  ask_rd_price;
  logic [PRICE_W-1:0]  ask_rd_vol;
  logic [PRICE_W-1:0]  bid_rd_price;
  logic [PRICE_W-1:0]  bid_rd_vol;

  logic                positive;
  logic                found;
  logic [CW-1:0]       cnt_sel;
  logic                full;
  logic                is_apply;
  logic                do_ow;
  logic                do_ins;
  logic                do_del;
  ctrl_t               ask_ctrl;
  ctrl_t               bid_ctrl;

  logic [CW-1:0]       cnt_res;
  logic [CW+LCNT_W-1:0] cnt_ext;
  logic                rank_ok;
  result_t             res_next;

  assign take      = req_valid & ~req_stall;
  assign req_stall = (state != S_IDLE);
  assign commit_go = (state == S_COMMIT) & (~res_valid | ~res_stall);

  always_comb begin
    case (state)
      S_IDLE:   state_next = take ? S_COMMIT : S_IDLE;
      S_COMMIT: state_next = commit_go ? S_IDLE : S_COMMIT;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      mode_q  <= req.mode;
      side_q  <= req.side;
      price_q <= req.price;
      vol_q   <= req.volume;
      upd_q   <= req.update_id;
      rank_q  <= req.rank;
    end
  end

  // apply decode
  assign positive = ~vol_q[VOL_W-1] & (vol_q != '0);
  assign found    = side_q ? bid_found : ask_found;
  assign cnt_sel  = side_q ? bid_cnt : ask_cnt;
  assign full     = (cnt_sel == CW'(LEVELS_PER_SIDE));
  assign is_apply = (mode_q == M_APPLY);
  assign do_ow    = is_apply & positive & found;
  assign do_ins   = is_apply & positive & ~found & ~full;
  assign do_del   = is_apply & ~positive & found;

  always_comb begin
    ask_ctrl     = '0;
    bid_ctrl     = '0;
    ask_ctrl.go  = commit_go & ~side_q;
    bid_ctrl.go  = commit_go & side_q;
    ask_ctrl.ins = do_ins;
    bid_ctrl.ins = do_ins;
    ask_ctrl.del = do_del;
    bid_ctrl.del = do_del;
    ask_ctrl.ow  = do_ow;
    bid_ctrl.ow  = do_ow;
  end

  opb_chain #(
    .LEVELS (LEVELS_PER_SIDE),
    .BID    (1'b0),
    .CW     (CW)
  ) u_ask (
    .clk       (clk),
    .cmp_en    (take),
    .key       (req.price),
    .rank      (req.rank),
    .cnt       (ask_cnt),
    .ctrl      (ask_ctrl),
    .new_price (price_q),
    .new_vol   (vol_q[PRICE_W-1:0]),
    .found     (ask_found),
    .rd_price  (ask_rd_price),
    .rd_vol    (ask_rd_vol)
  );

  opb_chain #(
    .LEVELS (LEVELS_PER_SIDE),
    .BID    (1'b1),
    .CW     (CW)
  ) u_bid (
    .clk       (clk),
    .cmp_en    (take),
    .key       (req.price),
    .rank      (req.rank),
    .cnt       (bid_cnt),
    .ctrl      (bid_ctrl),
    .new_price (price_q),
    .new_vol   (vol_q[PRICE_W-1:0]),
    .found     (bid_found),
    .rd_price  (bid_rd_price),
    .rd_vol    (bid_rd_vol)
  );

  always_comb begin
    ask_cnt_next = ask_cnt;
    bid_cnt_next = bid_cnt;
    uid_next     = uid;
    case (mode_q)
      M_APPLY: begin
        if (do_ins) begin
          if (side_q) begin
            bid_cnt_next = bid_cnt + CW'(1);
          end else begin
            ask_cnt_next = ask_cnt + CW'(1);
          end
        end else if (do_del) begin
          if (side_q) begin
            bid_cnt_next = bid_cnt - CW'(1);
          end else begin
            ask_cnt_next = ask_cnt - CW'(1);
          end
        end
      end
      M_SET_ID: begin
        uid_next = upd_q;
      end
      M_CLEAR: begin
        ask_cnt_next = '0;
        bid_cnt_next = '0;
        uid_next     = '1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ask_cnt <= '0;
      bid_cnt <= '0;
      uid     <= '1;
    end else if (commit_go) begin
      ask_cnt <= ask_cnt_next;
      bid_cnt <= bid_cnt_next;
      uid     <= uid_next;
    end
  end

  assign cnt_res = side_q ? bid_cnt_next : ask_cnt_next;
  assign cnt_ext = {{LCNT_W{1'b0}}, cnt_res};
  assign rank_ok = ({{CW{1'b0}}, rank_q} < {{RANK_W{1'b0}}, cnt_sel});

  always_comb begin
    res_next                = '0;
    res_next.level_count    = cnt_ext[LCNT_W-1:0];
    res_next.last_update_id = uid_next;
    case (mode_q)
      M_APPLY: begin
        res_next.status = (is_apply & positive & ~found & full) ? ST_FULL : ST_OK;
      end
      M_READ: begin
        if (rank_ok) begin
          res_next.status       = ST_OK;
          res_next.level_price  = side_q ? bid_rd_price : ask_rd_price;
          res_next.level_volume = side_q ? bid_rd_vol : ask_rd_vol;
        end else begin
          res_next.status = ST_RANK;
        end
      end
      default: begin
        res_next.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (commit_go) begin
      res_valid <= 1'b1;
    end else if (~res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      res <= res_next;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (ask_cnt <= CW'(LEVELS_PER_SIDE)) && (bid_cnt <= CW'(LEVELS_PER_SIDE)))
    else $error("level count above table size");

  a_ins_del_excl: assert property (@(posedge clk) disable iff (rst)
    !(do_ins && do_del))
    else $error("insert and delete in the same request");

  a_cnt_moves_on_commit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && (ask_cnt != $past(ask_cnt) || bid_cnt != $past(bid_cnt)))
    |-> $past(commit_go))
    else $error("level count changed outside a commit");

  a_take_to_commit: assert property (@(posedge clk) disable iff (rst)
    take |=> (state == S_COMMIT))
    else $error("taken request not in work");
`endif

endmodule

/* rtl/opb_cell.sv */
module opb_cell import opb_pkg::*; #(
  parameter int  IDX = 0,
  parameter bit  BID = 1'b0
) (
  input  logic               clk,
  input  logic               cmp_en,
  input  logic [PRICE_W-1:0] key,
  input  logic [RANK_W-1:0]  rank,
  input  logic               valid,
  input  ctrl_t              ctrl,
  input  logic [PRICE_W-1:0] new_price,
  input  logic [PRICE_W-1:0] new_vol,
  input  logic               lge,
  input  logic               lvalid,
  input  logic [PRICE_W-1:0] lprice,
  input  logic [PRICE_W-1:0] lvol,
  input  logic [PRICE_W-1:0] rprice,
  input  logic [PRICE_W-1:0] rvol,
  output logic               ge,
  output logic               eq,
  output logic               sel,
  output logic [PRICE_W-1:0] price,
  output logic [PRICE_W-1:0] vol
);

  localparam int RANK_MAX = (1 << RANK_W) - 1;

  logic key_eq;
  logic key_ahead;
  logic rank_hit;
  logic is_pos;

  assign key_eq    = (key == price);
  assign key_ahead = BID ? (key > price) : (key < price);
  assign rank_hit  = (IDX <= RANK_MAX) && (rank == RANK_W'(IDX));

  // insertion point: first cell at or behind the key, or first free cell
  assign is_pos = (ge | ~valid) & ((IDX == 0) ? 1'b1 : (~lge & lvalid));

  always_ff @(posedge clk) begin
    if (cmp_en) begin
      eq  <= valid & key_eq;
      ge  <= valid & (key_eq | key_ahead);
      sel <= valid & rank_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.go) begin
      if (ctrl.ow) begin
        if (eq) begin
          vol <= new_vol;
        end
      end else if (ctrl.ins) begin
        if (lge) begin
          price <= lprice;
          vol   <= lvol;
        end else if (is_pos) begin
          price <= new_price;
          vol   <= new_vol;
        end
      end else if (ctrl.del) begin
        if (ge) begin
          price <= rprice;
          vol   <= rvol;
        end
      end
    end
  end

endmodule

/* rtl/opb_chain.sv */
module opb_chain import opb_pkg::*; #(
  parameter int LEVELS = LEVELS_DEFAULT,
  parameter bit BID    = 1'b0,
  parameter int CW     = $clog2(LEVELS + 1)
) (
  input  logic               clk,
  input  logic               cmp_en,
  input  logic [PRICE_W-1:0] key,
  input  logic [RANK_W-1:0]  rank,
  input  logic [CW-1:0]      cnt,
  input  ctrl_t              ctrl,
  input  logic [PRICE_W-1:0] new_price,
  input  logic [PRICE_W-1:0] new_vol,
  output logic               found,
  output logic [PRICE_W-1:0] rd_price,
  output logic [PRICE_W-1:0] rd_vol
);

  logic [PRICE_W-1:0] pr [LEVELS];
  logic [PRICE_W-1:0] vl [LEVELS];
  logic [LEVELS-1:0]  ge_v;
  logic [LEVELS-1:0]  eq_v;
  logic [LEVELS-1:0]  sel_v;
  logic [LEVELS-1:0]  valid_v;

  for (genvar i = 0; i < LEVELS; i++) begin : g_cell
    logic               lge;
    logic               lvalid;
    logic [PRICE_W-1:0] lprice;
    logic [PRICE_W-1:0] lvol;
    logic [PRICE_W-1:0] rprice;
    logic [PRICE_W-1:0] rvol;

    assign valid_v[i] = (cnt > CW'(i));

    if (i == 0) begin : g_first
      assign lge    = 1'b0;
      assign lvalid = 1'b0;
      assign lprice = new_price;
      assign lvol   = new_vol;
    end else begin : g_mid
      assign lge    = ge_v[i-1];
      assign lvalid = valid_v[i-1];
      assign lprice = pr[i-1];
      assign lvol   = vl[i-1];
    end

    if (i == LEVELS - 1) begin : g_last
      assign rprice = pr[i];
      assign rvol   = vl[i];
    end else begin : g_inner
      assign rprice = pr[i+1];
      assign rvol   = vl[i+1];
    end

    opb_cell #(
      .IDX (i),
      .BID (BID)
    ) u_cell (
      .clk       (clk),
      .cmp_en    (cmp_en),
      .key       (key),
      .rank      (rank),
      .valid     (valid_v[i]),
      .ctrl      (ctrl),
      .new_price (new_price),
      .new_vol   (new_vol),
      .lge       (lge),
      .lvalid    (lvalid),
      .lprice    (lprice),
      .lvol      (lvol),
      .rprice    (rprice),
      .rvol      (rvol),
      .ge        (ge_v[i]),
      .eq        (eq_v[i]),
      .sel       (sel_v[i]),
      .price     (pr[i]),
      .vol       (vl[i])
    );
  end

  assign found = |eq_v;

  always_comb begin
    rd_price = '0;
    rd_vol   = '0;
    for (int i = 0; i < LEVELS; i++) begin
      rd_price = rd_price | (pr[i] & {PRICE_W{sel_v[i]}});
      rd_vol   = rd_vol   | (vl[i] & {PRICE_W{sel_v[i]}});
    end
  end

endmodule

/* tb/tb.sv */
module tb;
  import opb_pkg::*;

  localparam int LEVELS = LEVELS_DEFAULT;
  localparam int QUIET_LIMIT = 2000;
  localparam int END_CYCLES = 10;
  localparam int MAX_REPORTS = 10;
  localparam bit ASK = 1'b0;
  localparam bit BID = 1'b1;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [VOL_W-1:0] VOL_MAX = {1'b0, {(VOL_W-1){1'b1}}};
  localparam logic [VOL_W-1:0] VOL_MIN = {1'b1, {(VOL_W-1){1'b0}}};
  localparam logic [VOL_W-1:0] VOL_NEG_ONE = '1;
  localparam logic [UID_W-1:0] UID_MAX = {1'b0, {(UID_W-1){1'b1}}};
  localparam logic [UID_W-1:0] UID_MIN = {1'b1, {(UID_W-1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic res_valid;
  logic res_stall = 1'b0;
  result_t res;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int full_drops = 0;
  int rank_misses = 0;
  int deepest = 0;
  int quiet = 0;

  // book image: index 0 ask side, 1 bid side
  logic [PRICE_W-1:0] lvl_px [2][LEVELS];
  logic [PRICE_W-1:0] lvl_qty [2][LEVELS];
  int lvl_cnt [2] = '{0, 0};
  logic [UID_W-1:0] held_id = '1;
  result_t book_results [$];

  order_book_price_level_table_top dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  always #10 clk = ~clk;

  task automatic book_step(input req_t r);
    result_t e;
    int s, n, pos, i;
    bit found, positive;
    e = '0;
    s = int'(r.side);
    case (r.mode)
      M_APPLY: begin
        n = lvl_cnt[s];
        pos = n;
        found = 1'b0;
        positive = !r.volume[VOL_W-1] && (r.volume != '0);
        for (i = 0; i < n; i++) begin
          if (lvl_px[s][i] == r.price) begin
            pos = i;
            found = 1'b1;
            break;
          end
          if ((s == BID) ? (r.price > lvl_px[s][i]) : (r.price < lvl_px[s][i])) begin
            pos = i;
            break;
          end
        end
        if (positive) begin
          if (found) begin
            lvl_qty[s][pos] = r.volume[PRICE_W-1:0];
          end else if (n >= LEVELS) begin
            e.status = ST_FULL;
            full_drops++;
          end else begin
            for (i = n; i > pos; i--) begin
              lvl_px[s][i] = lvl_px[s][i-1];
              lvl_qty[s][i] = lvl_qty[s][i-1];
            end
            lvl_px[s][pos] = r.price;
            lvl_qty[s][pos] = r.volume[PRICE_W-1:0];
            lvl_cnt[s] = n + 1;
            if (n + 1 > deepest) deepest = n + 1;
          end
        end else if (found) begin
          for (i = pos; i + 1 < n; i++) begin
            lvl_px[s][i] = lvl_px[s][i+1];
            lvl_qty[s][i] = lvl_qty[s][i+1];
          end
          lvl_cnt[s] = n - 1;
        end
      end
      M_SET_ID: held_id = r.update_id;
      M_CLEAR: begin
        lvl_cnt[0] = 0;
        lvl_cnt[1] = 0;
        held_id = '1;
      end
      M_READ: begin
        if (r.rank < lvl_cnt[s]) begin
          e.level_price = lvl_px[s][r.rank];
          e.level_volume = lvl_qty[s][r.rank];
        end else begin
          e.status = ST_RANK;
          rank_misses++;
        end
      end
      default: begin
      end
    endcase
    e.level_count = LCNT_W'(lvl_cnt[s]);
    e.last_update_id = held_id;
    book_results.insert(book_results.size(), e);
  endtask

  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    book_step(r);
    n_sent++;
  endtask

  function automatic req_t mk(input logic [MODE_W-1:0] md, input bit sd,
                              input logic [PRICE_W-1:0] px, input logic [VOL_W-1:0] vol,
                              input logic [UID_W-1:0] uid, input logic [RANK_W-1:0] rk);
    req_t r;
    r.mode = md;
    r.side = sd;
    r.price = px;
    r.volume = vol;
    r.update_id = uid;
    r.rank = rk;
    return r;
  endfunction

  function automatic req_t rand_request(input bit sd, input logic [PRICE_W-1:0] px,
                                        input int insert_pct, input int read_pct,
                                        input int clear_pct);
    req_t r;
    int roll;
    r.mode = M_APPLY;
    r.side = sd;
    r.price = px;
    r.volume = {$urandom, $urandom};
    r.update_id = {$urandom, $urandom};
    r.rank = RANK_W'($urandom_range(63));
    roll = $urandom_range(99);
    if (roll < clear_pct) begin
      r.mode = M_CLEAR;
    end else if (roll < clear_pct + 4) begin
      r.mode = M_SET_ID;
    end else if (roll < clear_pct + 4 + read_pct) begin
      r.mode = M_READ;
      if ($urandom_range(3) != 0) r.rank = RANK_W'($urandom_range(lvl_cnt[sd]));
    end else if ($urandom_range(99) < insert_pct) begin
      r.volume[VOL_W-1] = 1'b0;
      if ($urandom_range(1) == 0) r.volume = VOL_W'($urandom_range(1000) + 1);
      if (r.volume == '0) r.volume = 1;
    end else begin
      case ($urandom_range(2))
        0: r.volume = '0;
        1: r.volume = VOL_NEG_ONE;
        default: r.volume[VOL_W-1] = 1'b1;
      endcase
    end
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: mismatch in %s at result %0d: expected %h, got %h",
               field, n_checked, want, got);
  endtask

  always @(posedge clk) begin : result_check
    result_t want;
    res_stall <= ($urandom_range(99) < recv_stall_pct);
    if (!rst && res_valid && !res_stall) begin
      if (book_results.size() == 0) begin
        note_mismatch("unexpected result", '0, res.last_update_id);
      end else begin
        want = book_results.pop_front();
        if (res.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(res.status));
        if (res.level_price !== want.level_price)
          note_mismatch("level_price", 64'(want.level_price), 64'(res.level_price));
        if (res.level_volume !== want.level_volume)
          note_mismatch("level_volume", 64'(want.level_volume), 64'(res.level_volume));
        if (res.level_count !== want.level_count)
          note_mismatch("level_count", 64'(want.level_count), 64'(res.level_count));
        if (res.last_update_id !== want.last_update_id)
          note_mismatch("last_update_id", want.last_update_id, res.last_update_id);
      end
      n_checked++;
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (res_valid && !res_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb: timeout with %0d results outstanding", book_results.size());
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic test_empty_book;
    send_request(mk(M_READ, ASK, '0, '0, '0, 0));
    send_request(mk(M_READ, BID, '0, '0, '0, 63));
    send_request(mk(M_SET_ID, ASK, '0, '0, UID_MAX, 0));
    send_request(mk(M_SET_ID, BID, '0, '0, UID_MIN, 0));
  endtask

  task automatic test_ask_extremes;
    send_request(mk(M_APPLY, ASK, PRICE_MAX, VOL_MAX, '0, 0));
    send_request(mk(M_APPLY, ASK, '0, 1, '0, 0));
    send_request(mk(M_APPLY, ASK, 5, 7, '0, 0));
    for (int i = 0; i < 4; i++) send_request(mk(M_READ, ASK, '0, '0, '0, RANK_W'(i)));
    // overwrite keeps the count
    send_request(mk(M_APPLY, ASK, 5, 9, '0, 0));
    send_request(mk(M_READ, ASK, '0, '0, '0, 1));
    // delete of a price not held
    send_request(mk(M_APPLY, ASK, 6, '0, '0, 0));
    send_request(mk(M_APPLY, ASK, '0, VOL_NEG_ONE, '0, 0));
    send_request(mk(M_APPLY, ASK, PRICE_MAX, VOL_MIN, '0, 0));
    send_request(mk(M_READ, ASK, '0, '0, '0, 0));
  endtask

  task automatic test_bid_order;
    send_request(mk(M_APPLY, BID, 10, 100, '0, 0));
    send_request(mk(M_APPLY, BID, 20, 200, '0, 0));
    send_request(mk(M_APPLY, BID, 15, 150, '0, 0));
    send_request(mk(M_READ, BID, '0, '0, '0, 0));
    send_request(mk(M_READ, BID, '0, '0, '0, 2));
  endtask

  task automatic test_clear_book;
    send_request(mk(M_CLEAR, BID, '0, '0, '0, 0));
    send_request(mk(M_READ, BID, '0, '0, '0, 0));
  endtask

  task automatic test_random_book(input int idle_pct, input int stall_pct, input int items);
    int done, kind, len;
    bit sd;
    logic [PRICE_W-1:0] base;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    done = 0;
    while (done < items) begin
      kind = $urandom_range(3);
      sd = 1'($urandom_range(1));
      base = PRICE_W'({$urandom, $urandom});
      case (kind)
        // few prices: overwrites, deletes of held levels
        0: begin
          len = $urandom_range(40, 20);
          for (int j = 0; j < len; j++)
            send_request(rand_request(sd, base + $urandom_range(7), 60, 18, 0));
        end
        // 90 distinct prices, more than the side holds, then repeats
        1: begin
          len = 100;
          for (int j = 0; j < len; j++)
            send_request(rand_request(sd, base + (j * 37) % 90, 97, 5, 0));
        end
        2: begin
          len = $urandom_range(40, 20);
          for (int j = 0; j < len; j++)
            send_request(rand_request(sd, PRICE_W'({$urandom, $urandom}), 70, 18, 0));
        end
        default: begin
          len = $urandom_range(20, 10);
          for (int j = 0; j < len; j++)
            send_request(rand_request(1'($urandom_range(1)),
                                      PRICE_W'(($urandom_range(1) == 0) ?
                                               {$urandom, $urandom} :
                                               base + $urandom_range(3)),
                                      50, 18, 8));
        end
      endcase
      done += len;
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 30;
    recv_stall_pct = 79;
    test_empty_book();
    test_ask_extremes();
    test_bid_order();
    test_clear_book();
    test_random_book(30, 79, 300);
    test_random_book(79, 30, 300);
    test_random_book(0, 0, 300);
    req_valid <= 1'b0;
    while (book_results.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    $display("tb: %0d requests over three idling phases, %0d results checked, %0d mismatches",
             n_sent, n_checked, mismatches);
    $display("tb: %0d inserts dropped on a full side, %0d reads past the count, deepest side %0d",
             full_drops, rank_misses, deepest);
    if (mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
